// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared clocking and reporting for the concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge, muted while reset is high
`define NZH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every rising edge, reset included
`define NZH_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/nzh_pkg.sv =====
// ----------------------------------------------------------------------------
// nzh_pkg
// shared types and codes of the nucleotide zobrist hasher
// ----------------------------------------------------------------------------
package nzh_pkg;

   localparam int NUM_LANES = 4;
   localparam int HASH_W    = 64;

   // operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_HASH = 1'b1;

   // position shift codes, the reserved code acts as plain
   localparam logic [1:0] SHIFT_PLAIN  = 2'd0;
   localparam logic [1:0] SHIFT_DELETE = 2'd1;
   localparam logic [1:0] SHIFT_INSERT = 2'd2;
   localparam logic [1:0] SHIFT_RSVD   = 2'd3;

   // what one lane found for its base
   typedef struct packed {
      logic hit;   // table word takes part in the hash
      logic oor;   // effective position past the table
   } lane_status_type;

   // control of the item in the merge stage
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } stage_ctrl_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash_value;
      logic              range_exceeded;
   } result_type;

endpackage

// ===== sv/nucleotide_zobrist_hasher_top.sv =====
// ----------------------------------------------------------------------------
// nucleotide_zobrist_hasher_top
// zobrist hash of packed dna bytes, four base lanes and a merge stage
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_stall   operation, table entry, bases, flags
//   rsp_      out         rsp_valid/rsp_stall   hash value, range exceeded
//
// - one word is taken every cycle while req_stall is low, load words and hash
//   words alike
// - the result of a hash word on its last byte reaches rsp_ through the result
//   buffer: the lane table reads register at the edge that takes the word and
//   the merge writes the result buffer at the next edge
// - each lane owns a full table copy, so the four reads of a byte share no
//   memory port; load words write all four copies at once
// - reset clears the control state only; the table is undefined until loaded
//   and has no clearing pass
// - results queue in a two-word buffer; req_stall is high whenever that buffer,
//   counting the word the merge stage writes at this edge, would hold two
//   words after the edge, for load words too
//
module nucleotide_zobrist_hasher_top #(
   parameter int MAX_BASES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [11:0] req_table_index,
   input  logic [63:0] req_table_word,
   input  logic [7:0]  req_packed_bases,
   input  logic [2:0]  req_base_count,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [1:0]  req_position_shift,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value,
   output logic        rsp_range_exceeded
);
   import nzh_pkg::*;

   localparam int TABLE_WORDS = 4 * MAX_BASES;
   localparam int AW          = $clog2(TABLE_WORDS);
   localparam int PW          = $clog2(MAX_BASES + 8);
   localparam logic [PW-1:0] CAP = PW'(MAX_BASES + 1);

   // accept and word kind
   logic            accept;
   logic            hash_take;
   logic            load_take;

   // position state, updated as a hash word is taken
   logic [PW-1:0]   pos_ff;
   logic [PW-1:0]   pos_in;
   logic [1:0]      mode_ff;
   logic [1:0]      mode_eff;
   logic [PW-1:0]   start_pos;
   logic [2:0]      count_clamp;
   logic [PW-1:0]   pos_sum;

   // load address
   logic [31:0]     load_idx;
   logic            load_ok;

   // merge stage control
   stage_ctrl_type  ctrl_ff;
   stage_ctrl_type  ctrl_in;

   // lane results
   logic [63:0]     lane_word   [NUM_LANES];
   lane_status_type lane_status [NUM_LANES];

   // result queue
   logic            push;
   result_type      push_data;
   result_type      out_data;
   logic [1:0]      level;
   logic            pop;
   logic [2:0]      level_next;

   assign accept    = req_valid && !req_stall;
   assign hash_take = accept && (req_operation == OP_HASH);
   assign load_take = accept && (req_operation == OP_LOAD);

   // a first byte restarts the sequence and latches the shift mode
   always_comb begin
      start_pos   = req_first_byte ? '0 : pos_ff;
      if (req_first_byte) begin
         mode_eff = (req_position_shift == SHIFT_RSVD) ? SHIFT_PLAIN : req_position_shift;
      end else begin
         mode_eff = mode_ff;
      end
      count_clamp = (req_base_count > 3'd4) ? 3'd4 : req_base_count;
      pos_sum     = start_pos + PW'(count_clamp);
      // position saturates at MAX_BASES + 1, so a delete shift still lands past the table
      pos_in      = (pos_sum > CAP) ? CAP : pos_sum;
   end

   // loads past a shortened table are dropped
   assign load_idx = 32'(req_table_index);
   assign load_ok  = load_take && (load_idx < 32'(TABLE_WORDS));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         mode_ff <= SHIFT_PLAIN;
      end else if (hash_take) begin
         pos_ff  <= pos_in;
         mode_ff <= mode_eff;
      end
   end

   // four lanes, one per base of the byte
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      nzh_lane #(
         .MAX_BASES (MAX_BASES),
         .LANE      (k)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .rd_en     (hash_take),
         .start_pos (start_pos),
         .mode      (mode_eff),
         .lane_en   (3'(k) < count_clamp),
         .base      (req_packed_bases[2*k +: 2]),
         .wr_en     (load_ok),
         .wr_addr   (load_idx[AW-1:0]),
         .wr_data   (req_table_word),
         .rd_word   (lane_word[k]),
         .status    (lane_status[k])
      );
   end

   always_comb begin
      ctrl_in.valid = hash_take;
      ctrl_in.first = req_first_byte;
      ctrl_in.last  = req_last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   // xor of the lane words into the running hash
   nzh_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl_ff),
      .lane_word   (lane_word),
      .lane_status (lane_status),
      .push        (push),
      .result      (push_data)
   );

   nzh_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .level     (level)
   );

   // room check: queue fill after this edge, counting the merge stage word
   assign pop        = rsp_valid && !rsp_stall;
   assign level_next = {1'b0, level} - {2'b00, pop} + {2'b00, push};
   assign req_stall  = (level_next >= 3'd2);

   assign rsp_hash_value     = out_data.hash_value;
   assign rsp_range_exceeded = out_data.range_exceeded;

endmodule

// ===== sv/nzh_lane.sv =====
// ----------------------------------------------------------------------------
// nzh_lane
// one base lane: effective position, table address and its own table copy
// ----------------------------------------------------------------------------
module nzh_lane #(
   parameter  int MAX_BASES = 1024,
   parameter  int LANE      = 0,
   localparam int AW        = $clog2(4 * MAX_BASES),
   localparam int PW        = $clog2(MAX_BASES + 8)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [PW-1:0]           start_pos,
   input  logic [1:0]              mode,
   input  logic                    lane_en,
   input  logic [1:0]              base,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic [63:0]             wr_data,
   output logic [63:0]             rd_word,
   output nzh_pkg::lane_status_type status
);
   import nzh_pkg::*;

   localparam int TABLE_WORDS = 4 * MAX_BASES;
   localparam logic [PW-1:0] CAP  = PW'(MAX_BASES + 1);
   localparam logic [PW-1:0] LIM  = PW'(MAX_BASES);
   localparam logic [PW-1:0] OFFS = PW'(LANE);

   logic [63:0]     table_ff [TABLE_WORDS];
   logic [63:0]     rd_word_ff;
   lane_status_type status_ff;
   lane_status_type status_in;
   logic [PW-1:0]   pos_raw;
   logic [PW-1:0]   pos;
   logic [PW-1:0]   eff;
   logic            skip;
   logic [AW-1:0]   rd_addr;

   always_comb begin
      pos_raw = start_pos + OFFS;
      pos     = (pos_raw > CAP) ? CAP : pos_raw;
      skip    = 1'b0;
      case (mode)
         SHIFT_DELETE: begin
            skip = (pos == '0);
            eff  = pos - PW'(1);
         end
         SHIFT_INSERT: eff = pos + PW'(1);
         default:      eff = pos;
      endcase
      status_in.oor = lane_en && !skip && (eff >= LIM);
      status_in.hit = lane_en && !skip && (eff < LIM);
      rd_addr       = {eff[AW-3:0], base};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= table_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
      end else if (rd_en) begin
         status_ff <= status_in;
      end
   end

   assign rd_word = rd_word_ff;
   assign status  = status_ff;

endmodule

// ===== sv/nzh_merge.sv =====
// ----------------------------------------------------------------------------
// nzh_merge
// folds the lane words into the running hash and range flag
// ----------------------------------------------------------------------------
module nzh_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  nzh_pkg::stage_ctrl_type ctrl,
   input  logic [63:0]             lane_word [nzh_pkg::NUM_LANES],
   input  nzh_pkg::lane_status_type lane_status [nzh_pkg::NUM_LANES],
   output logic                    push,
   output nzh_pkg::result_type     result
);
   import nzh_pkg::*;

   logic [HASH_W-1:0] hash_ff;
   logic [HASH_W-1:0] hash_in;
   logic              flag_ff;
   logic              flag_in;
   logic [HASH_W-1:0] lane_xor;
   logic              lane_oor;

   always_comb begin
      lane_xor = '0;
      lane_oor = 1'b0;
      for (int k = 0; k < NUM_LANES; k++) begin
         if (lane_status[k].hit) begin
            lane_xor = lane_xor ^ lane_word[k];
         end
         lane_oor = lane_oor | lane_status[k].oor;
      end
      hash_in = (ctrl.first ? '0 : hash_ff) ^ lane_xor;
      flag_in = (ctrl.first ? 1'b0 : flag_ff) | lane_oor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         flag_ff <= 1'b0;
      end else if (ctrl.valid) begin
         hash_ff <= hash_in;
         flag_ff <= flag_in;
      end
   end

   assign push                  = ctrl.valid && ctrl.last;
   assign result.hash_value     = hash_in;
   assign result.range_exceeded = flag_in;

endmodule

// ===== sv/nzh_outq.sv =====
// ----------------------------------------------------------------------------
// nzh_outq
// two-word result queue that parts the pipeline from the result channel
// ----------------------------------------------------------------------------
module nzh_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nzh_pkg::result_type push_data,
   input  logic                out_stall,
   output logic                out_valid,
   output nzh_pkg::result_type out_data,
   output logic [1:0]          level
);
   import nzh_pkg::*;

   result_type  entry_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        pop;

   assign pop       = out_valid && !out_stall;
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign level     = count_ff;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/nzh_checker.sv =====
// ----------------------------------------------------------------------------
// nzh_checker
// port-level checks of the hasher, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nzh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_operation,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_hash_value,
   input logic        rsp_range_exceeded
);
   import nzh_pkg::*;

   logic        hash_last_take;
   logic        rsp_held;
   logic [64:0] rsp_word;

   assign hash_last_take = req_valid && !req_stall && (req_operation == OP_HASH) &&
                           req_last_byte;
   assign rsp_held       = rsp_valid && rsp_stall;
   assign rsp_word       = {rsp_hash_value, rsp_range_exceeded};

   // a held result word stays offered
   `NZH_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid, "result dropped under stall")

   // and keeps its payload
   `NZH_ASSERT(a_rsp_stable, rsp_held |=> $stable(rsp_word), "result changed under stall")

   // an empty output only fills from an earlier taken last byte of a hash word
   `NZH_ASSERT(a_rsp_origin, $rose(rsp_valid) |-> $past(hash_last_take, 2), "stray result")

   // reset empties the result queue
   `NZH_ASSERT_RST(a_rsp_reset, reset |=> !rsp_valid, "result offered after reset")

endmodule

bind nucleotide_zobrist_hasher_top nzh_checker u_nzh_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_operation      (req_operation),
   .req_last_byte      (req_last_byte),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_hash_value     (rsp_hash_value),
   .rsp_range_exceeded (rsp_range_exceeded)
);
